// ===== design/rcr_pkg.sv =====
`timescale 1ns / 1ps

package rcr_pkg;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_DRAW  = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BG     = 2'd2;

    localparam int ONE_UNIT = 256;

    // rectangle edges in Q12.8; right/bottom carry one extra bit so nothing wraps
    typedef struct packed {
        logic signed [19:0] left;
        logic signed [19:0] top;
        logic signed [20:0] right;
        logic signed [20:0] bottom;
        logic               fill;
    } t_rect;

endpackage

// ===== design/rcr_ram.sv =====
`timescale 1ns / 1ps

module rcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 262144
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/rcr_cover.sv =====
`timescale 1ns / 1ps

module rcr_cover import rcr_pkg::*; #(
    parameter int CW = 9
) (
    input  logic [CW-1:0] i_col,
    input  logic [CW-1:0] i_row,
    input  t_rect         i_rect,
    output logic          o_paint
);

    localparam int DW = (CW + 10 > 23) ? CW + 10 : 23;

    logic signed [DW-1:0] px, py;
    logic signed [DW-1:0] left_x, top_x, right_x, bottom_x;
    logic signed [DW-1:0] dl, dr, dt, db;
    logic signed [DW-1:0] unit;
    logic                 in_rect, edge_near;

    assign px       = $signed({{(DW-CW-8){1'b0}}, i_col, 8'b0});
    assign py       = $signed({{(DW-CW-8){1'b0}}, i_row, 8'b0});
    assign left_x   = DW'(i_rect.left);
    assign top_x    = DW'(i_rect.top);
    assign right_x  = DW'(i_rect.right);
    assign bottom_x = DW'(i_rect.bottom);
    assign unit     = DW'(ONE_UNIT);

    assign dl = px - left_x;
    assign dr = right_x - px;
    assign dt = py - top_x;
    assign db = bottom_x - py;

    assign in_rect   = !dl[DW-1] && !dr[DW-1] && !dt[DW-1] && !db[DW-1];
    assign edge_near = (dl < unit) || (dr < unit) || (dt < unit) || (db < unit);
    assign o_paint   = in_rect && (i_rect.fill || edge_near);

endmodule

// ===== design/rect_canvas_rasterizer.sv =====
`timescale 1ns / 1ps

// Character canvas rasterizer. Assert start with the item fields while busy is
// low; the request is taken on that edge. A clear or a draw sweeps the canvas in
// use one pixel per cycle through the canvas memory's single write port, so it
// keeps busy high until all width*height pixels (up to MAX_SIDE*MAX_SIDE) are
// visited, and o_done pulses as busy falls. A read goes through the memory's
// registered read port and then the S_READ state before o_done pulses. A draw
// with zero width or height, or an unused kind, pulses o_done on the next cycle
// without touching the canvas. o_done is a single-cycle strobe and cannot be
// held off, so the receiver must capture o_status and o_pixel_value on it. The
// canvas content is undefined after reset until a clear or a draw writes it. The
// user must make configuration writes while busy is low; it is not enforced.
module rect_canvas_rasterizer import rcr_pkg::*; #(
    parameter int MAX_SIDE = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [9:0]         i_cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_kind,
    input  logic signed [19:0] i_rect_left,
    input  logic signed [19:0] i_rect_top,
    input  logic [18:0]        i_rect_width,
    input  logic [18:0]        i_rect_height,
    input  logic               i_filled,
    input  logic [7:0]         i_paint_char,
    input  logic [8:0]         i_pixel_col,
    input  logic [8:0]         i_pixel_row,
    output logic               o_done,
    output logic               o_status,
    output logic [7:0]         o_pixel_value
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int LW = (SW > 10) ? SW : 10;
    localparam int AW = 2 * CW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0]    r_state;
    logic [9:0]    r_canvas_width, r_canvas_height;
    logic [7:0]    r_bg;
    logic [CW-1:0] r_col, r_row;
    logic          r_clear;
    logic [7:0]    r_char;
    t_rect         r_rect;
    logic          r_rd_ok;
    logic          r_done, r_status;
    logic [7:0]    r_value;

    logic [LW-1:0] cw_ext, ch_ext, col_ext, row_ext;
    logic [SW-1:0] cw, ch;
    logic          accept, rect_empty, paint, last_col, last_row;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    // clamp the sizes in use to 1..MAX_SIDE
    always_comb begin
        cw_ext = LW'(r_canvas_width);
        ch_ext = LW'(r_canvas_height);
        if (cw_ext == '0) begin
            cw_ext = LW'(1);
        end else if (cw_ext > LW'(MAX_SIDE)) begin
            cw_ext = LW'(MAX_SIDE);
        end
        if (ch_ext == '0) begin
            ch_ext = LW'(1);
        end else if (ch_ext > LW'(MAX_SIDE)) begin
            ch_ext = LW'(MAX_SIDE);
        end
    end

    assign cw = cw_ext[SW-1:0];
    assign ch = ch_ext[SW-1:0];

    assign col_ext    = LW'(i_pixel_col);
    assign row_ext    = LW'(i_pixel_row);
    assign accept     = start && (r_state == S_IDLE);
    assign busy       = (r_state != S_IDLE);
    assign rect_empty = (i_rect_width == '0) || (i_rect_height == '0);
    assign last_col   = (SW'(r_col) == cw - SW'(1));
    assign last_row   = (SW'(r_row) == ch - SW'(1));

    rcr_cover #(
        .CW (CW)
    ) u_cover (
        .i_col   (r_col),
        .i_row   (r_row),
        .i_rect  (r_rect),
        .o_paint (paint)
    );

    assign mem_we    = (r_state == S_WALK) && (r_clear || paint);
    assign mem_waddr = {r_row, r_col};
    assign mem_wdata = r_clear ? r_bg : r_char;
    assign mem_re    = accept && (i_kind == KIND_READ);
    assign mem_raddr = {row_ext[CW-1:0], col_ext[CW-1:0]};

    rcr_ram #(
        .WIDTH (8),
        .DEPTH (2 ** AW)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_width  <= 10'd1;
            r_canvas_height <= 10'd1;
            r_bg            <= 8'd32;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WIDTH:  r_canvas_width  <= i_cfg_data;
                CFG_HEIGHT: r_canvas_height <= i_cfg_data;
                CFG_BG:     r_bg            <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // item payload latched on the request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_clear       <= (i_kind == KIND_CLEAR);
            r_char        <= i_paint_char;
            r_rect.left   <= i_rect_left;
            r_rect.top    <= i_rect_top;
            r_rect.right  <= 21'(i_rect_left) + $signed({2'b0, i_rect_width});
            r_rect.bottom <= 21'(i_rect_top) + $signed({2'b0, i_rect_height});
            r_rect.fill   <= i_filled;
            r_rd_ok       <= (col_ext < cw_ext) && (row_ext < ch_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_col <= '0;
                    r_row <= '0;
                    if (start) begin
                        priority if (i_kind == KIND_CLEAR) begin
                            r_state <= S_WALK;
                        end else if (i_kind == KIND_DRAW && !rect_empty) begin
                            r_state <= S_WALK;
                        end else if (i_kind == KIND_READ) begin
                            r_state <= S_READ;
                        end else begin
                            r_done <= 1'b1;
                        end
                    end
                end
                S_WALK: begin
                    if (last_col) begin
                        r_col <= '0;
                        if (last_row) begin
                            r_state <= S_IDLE;
                            r_done  <= 1'b1;
                        end else begin
                            r_row <= r_row + CW'(1);
                        end
                    end else begin
                        r_col <= r_col + CW'(1);
                    end
                end
                S_READ: begin
                    r_state <= S_IDLE;
                    r_done  <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= (i_kind == KIND_DRAW) && rect_empty;
            r_value  <= '0;
        end else if (r_state == S_READ) begin
            r_value  <= r_rd_ok ? mem_rdata : 8'd0;
        end
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_pixel_value = r_value;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while still busy");

    a_accept_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("request neither started work nor produced a result");

    a_error_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_pixel_value == 8'd0))
        else $error("error result carries a pixel value");

    a_walk_in_canvas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ((SW'(r_col) < cw) && (SW'(r_row) < ch)))
        else $error("sweep address outside the canvas in use");

endmodule
